// ===== rtl/swr_pkg.sv =====
package swr_pkg;

    localparam int NUM_WAYS = 8;
    localparam int NUM_SETS = 256;

    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    // only sets below 256 can be addressed by an 8-bit index
    localparam int VLD_N = (NUM_SETS < 256) ? NUM_SETS : 256;
    localparam int VLD_W = (VLD_N > 1) ? $clog2(VLD_N) : 1;

    localparam logic [1:0] OP_TOUCH = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;

    typedef logic [NUM_WAYS-1:0] t_marks;
    typedef logic [SET_W-1:0]    t_set_addr;

    typedef struct packed {
        logic      rd;
        logic      wr;
        t_set_addr addr;
        t_marks    vis;
        t_marks    saf;
    } t_store_req;

endpackage

// ===== rtl/swr_if.sv =====
interface swr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] set_index;
    logic [2:0] way;

    modport source (output valid, output operation, output set_index, output way,
                    input ready);
    modport sink   (input valid, input operation, input set_index, input way,
                    output ready);
endinterface

interface swr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] victim_way;
    logic       victim_proper;

    modport source (output valid, output victim_way, output victim_proper,
                    input ready);
    modport sink   (input valid, input victim_way, input victim_proper,
                    output ready);
endinterface

// ===== rtl/swr_mark_store.sv =====
module swr_mark_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swr_pkg::t_store_req i_req,
    output swr_pkg::t_marks     o_vis,
    output swr_pkg::t_marks     o_saf
);
    import swr_pkg::*;

    t_marks            r_vis_mem [NUM_SETS];
    t_marks            r_saf_mem [NUM_SETS];
    logic [VLD_N-1:0]  r_written;
    t_marks            r_rd_vis;
    t_marks            r_rd_saf;
    logic              r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_vis_mem[i_req.addr] <= i_req.vis;
            r_saf_mem[i_req.addr] <= i_req.saf;
        end
        if (i_req.rd) begin
            r_rd_vis <= r_vis_mem[i_req.addr];
            r_rd_saf <= r_saf_mem[i_req.addr];
        end
    end

    // a set never written since reset reads as all zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_req.wr) begin
                r_written[VLD_W'(i_req.addr)] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_ok <= r_written[VLD_W'(i_req.addr)];
            end
        end
    end

    assign o_vis = r_rd_ok ? r_rd_vis : '0;
    assign o_saf = r_rd_ok ? r_rd_saf : '0;

endmodule

// ===== rtl/sieve_way_replacement_core.sv =====
// Touch / clear: set reduce, read, load, write from acceptance, no result.
// Find victim: set reduce, read, load, scan of k ways (1..NUM_WAYS), write; the write stage
// registers the result, waiting while an earlier one is still held in the output register.
// A new request is taken only once the core is back in idle; an ignored one (unknown operation)
// leaves it idle. Ready is high only while idle.
// Synchronous active-low reset; per-set written flags make the store read as cleared at once.
module sieve_way_replacement_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swr_req_if.sink   i_req,
    swr_rsp_if.source o_rsp
);
    import swr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_op, n_op;
    logic [7:0]       r_set, n_set;
    logic [WAY_W-1:0] r_way, n_way;
    logic [WAY_W-1:0] r_cnt, n_cnt;
    t_marks           r_vis, n_vis;
    t_marks           r_saf, n_saf;
    logic [2:0]       r_victim, n_victim;
    logic             r_proper, n_proper;
    logic [2:0]       r_out_way, n_out_way;
    logic             r_out_proper, n_out_proper;

    t_store_req       store_req;
    t_marks           rd_vis;
    t_marks           rd_saf;
    t_marks           way_bit;
    t_marks           unsafe;
    logic             take;

    swr_mark_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_vis   (rd_vis),
        .o_saf   (rd_saf)
    );

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.victim_way    = r_out_way;
    assign o_rsp.victim_proper = r_out_proper;

    assign take    = i_req.valid && (r_state == S_IDLE);
    assign way_bit = t_marks'(1) << r_way;
    assign unsafe  = ~rd_saf;

    always_comb begin
        store_req.rd   = (r_state == S_READ);
        store_req.wr   = (r_state == S_WRITE);
        store_req.addr = SET_W'(r_set);
        store_req.vis  = r_vis;
        store_req.saf  = r_saf;
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_op         = r_op;
        n_set        = r_set;
        n_way        = r_way;
        n_cnt        = r_cnt;
        n_vis        = r_vis;
        n_saf        = r_saf;
        n_victim     = r_victim;
        n_proper     = r_proper;
        n_out_way    = r_out_way;
        n_out_proper = r_out_proper;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_op  = i_req.operation;
                    n_set = i_req.set_index;
                    n_way = WAY_W'(i_req.way);
                    if (i_req.operation == OP_FIND ||
                        ((i_req.operation == OP_TOUCH || i_req.operation == OP_CLEAR) &&
                         int'(i_req.way) < NUM_WAYS)) begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // wrap the set index by repeated subtraction
                if (int'(r_set) >= NUM_SETS) begin
                    n_set = r_set - 8'(NUM_SETS);
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_vis   = rd_vis;
                n_saf   = rd_saf;
                n_cnt   = '0;
                n_state = S_WRITE;
                case (r_op)
                    OP_TOUCH: begin
                        n_vis = rd_vis | way_bit;
                    end
                    OP_CLEAR: begin
                        n_vis = rd_vis & ~way_bit;
                        n_saf = rd_saf & ~way_bit;
                    end
                    default: begin
                        // age the set when no unsafe way is unvisited
                        if ((unsafe & ~rd_vis) == '0) begin
                            n_vis = rd_vis & ~unsafe;
                            n_saf = '0;
                        end
                        n_state = S_SCAN;
                    end
                endcase
            end
            S_SCAN: begin
                if (!r_saf[r_cnt] && !r_vis[r_cnt]) begin
                    n_victim = 3'(r_cnt);
                    n_proper = 1'b1;
                    n_state  = S_WRITE;
                end else begin
                    if (!r_saf[r_cnt]) begin
                        n_saf[r_cnt] = 1'b1;
                        n_vis[r_cnt] = 1'b0;
                    end
                    if (r_cnt == WAY_W'(NUM_WAYS - 1)) begin
                        n_victim = 3'(NUM_WAYS - 1);
                        n_proper = 1'b0;
                        n_state  = S_WRITE;
                    end else begin
                        n_cnt = r_cnt + WAY_W'(1);
                    end
                end
            end
            S_WRITE: begin
                if (r_op != OP_FIND) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_rsp.ready) begin
                    // hold the write until the result slot is free
                    n_out_valid  = 1'b1;
                    n_out_way    = r_victim;
                    n_out_proper = r_proper;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_set        <= n_set;
        r_way        <= n_way;
        r_cnt        <= n_cnt;
        r_vis        <= n_vis;
        r_saf        <= n_saf;
        r_victim     <= n_victim;
        r_proper     <= n_proper;
        r_out_way    <= n_out_way;
        r_out_proper <= n_out_proper;
    end

endmodule
